@@ sv/satc_pkg.sv @@
// Package for the sentence-aware text chunker.
// Holds beat types, offset width, register codes and character class helpers.
// No dependencies.
package satc_pkg;

  localparam int unsigned OFFSET_BITS = 24;
  localparam int unsigned CU_BITS     = 16;
  localparam int unsigned CFG_BITS    = 16;

  localparam logic [OFFSET_BITS-1:0] MAX_LEN = {OFFSET_BITS{1'b1}};

  localparam logic [CFG_BITS-1:0] CHUNK_SIZE_RST = CFG_BITS'(512);
  localparam logic [CFG_BITS-1:0] OVERLAP_RST    = CFG_BITS'(64);

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_CHUNK_SIZE = 1'b0,
    REG_OVERLAP    = 1'b1
  } reg_idx_e;

  localparam logic [CU_BITS-1:0] CU_PERIOD   = 16'h002E;
  localparam logic [CU_BITS-1:0] CU_EXCLAIM  = 16'h0021;
  localparam logic [CU_BITS-1:0] CU_QUESTION = 16'h003F;

  typedef struct packed {
    logic [CU_BITS-1:0] code_unit;
    logic               last;
  } in_beat_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] chunk_start;
    logic [OFFSET_BITS-1:0] chunk_end;
    logic                   final_chunk;
    logic                   length_overflow;
  } out_beat_t;

  // Unicode White_Space within the BMP
  function automatic logic is_white(input logic [CU_BITS-1:0] c);
    logic w;
    w = ((c >= 16'h0009) && (c <= 16'h000D)) || (c == 16'h0020) ||
        (c == 16'h0085) || (c == 16'h00A0) || (c == 16'h1680) ||
        ((c >= 16'h2000) && (c <= 16'h200A)) || (c == 16'h2028) ||
        (c == 16'h2029) || (c == 16'h202F) || (c == 16'h205F) ||
        (c == 16'h3000);
    return w;
  endfunction

  function automatic logic is_terminator(input logic [CU_BITS-1:0] c);
    return (c == CU_PERIOD) || (c == CU_EXCLAIM) || (c == CU_QUESTION);
  endfunction

endpackage

@@ sv/sentence_aware_text_chunker.sv @@
// Sentence-aware text chunker, top level.
// Depends on satc_pkg (beat types, offset width, character classes).
//
// Results: result beats are registered into the result queue when the code unit is accepted.
// Throughput: one code unit per cycle; results drain one per cycle, with
//   out_ready_i high, from a 4-entry queue; input stalls while >2 results wait.
// Reset (rst_ni low, async): text state cleared, chunk_size = 512, overlap = 64.
module sentence_aware_text_chunker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // APB-style config port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // code unit stream
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  satc_pkg::in_beat_t   in_data_i,
  // chunk stream
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output satc_pkg::out_beat_t  out_data_o
);

  localparam int unsigned OB    = satc_pkg::OFFSET_BITS;
  localparam int unsigned CB    = satc_pkg::CFG_BITS;
  localparam int unsigned QLEN  = 4;
  localparam int unsigned QPTR  = $clog2(QLEN);
  localparam int unsigned QCNT  = $clog2(QLEN + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CB-1:0] chunk_size_q, overlap_q;
  logic          cfg_wr;
  satc_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = satc_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_size_q <= satc_pkg::CHUNK_SIZE_RST;
      overlap_q    <= satc_pkg::OVERLAP_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        satc_pkg::REG_CHUNK_SIZE: chunk_size_q <= pwdata[CB-1:0];
        satc_pkg::REG_OVERLAP:    overlap_q    <= pwdata[CB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      satc_pkg::REG_CHUNK_SIZE: prdata = {{(32-CB){1'b0}}, chunk_size_q};
      satc_pkg::REG_OVERLAP:    prdata = {{(32-CB){1'b0}}, overlap_q};
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Text state
  // ---------------------------------------------------------------------------
  logic [OB-1:0] position_q, window_start_q, split_candidate_q;
  logic          candidate_valid_q, prev_term_q, overflowed_q;

  // result queue
  satc_pkg::out_beat_t q_mem [QLEN];
  logic [QPTR-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT-1:0] count_q;

  logic accept, pop;
  assign in_ready_o  = (count_q <= QCNT'(QLEN - 2));
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o & out_ready_i;
  assign out_data_o  = q_mem[rd_ptr_q];

  // ---------------------------------------------------------------------------
  // Per-beat datapath: all of it settles within the accept cycle
  // ---------------------------------------------------------------------------
  logic [CB-1:0] csz;
  logic          full;          // text already at max length, unit dropped
  logic          cand_hit;      // terminator followed by whitespace ends here
  logic [OB-1:0] cand;
  logic          cand_vld;
  logic [OB:0]   wend, lo;
  logic          fire;          // window decided by this unit
  logic [OB-1:0] split_end, ns_min, ns;
  logic [OB-1:0] ov_ext, pos_next, ws_next;
  logic          ovf_next;
  satc_pkg::out_beat_t res_split, res_final, res0, res1;
  logic [1:0]    n_res;

  always_comb begin
    csz      = (chunk_size_q == '0) ? CB'(1) : chunk_size_q;
    full     = (position_q >= satc_pkg::MAX_LEN);
    cand_hit = !full && prev_term_q && satc_pkg::is_white(in_data_i.code_unit);
    cand     = cand_hit ? position_q : split_candidate_q;
    cand_vld = cand_hit | candidate_valid_q;

    wend = {1'b0, window_start_q} + (OB+1)'(csz);
    lo   = {1'b0, window_start_q} + (OB+1)'(csz >> 1) + (OB+1)'(1);
    fire = !full && ({1'b0, position_q} >= wend);

    // split after the latest candidate in the window's second half
    if (cand_vld && ({1'b0, cand} >= lo) && ({1'b0, cand} <= wend)) begin
      split_end = cand;
    end else begin
      split_end = wend[OB-1:0];
    end

    ov_ext = OB'(overlap_q);
    ns_min = window_start_q + OB'(1);
    if ((split_end >= ov_ext) && ((split_end - ov_ext) > ns_min)) begin
      ns = split_end - ov_ext;
    end else begin
      ns = ns_min;
    end

    pos_next = full ? position_q : position_q + OB'(1);
    ws_next  = fire ? ns : window_start_q;
    ovf_next = overflowed_q | full;

    res_split.chunk_start     = window_start_q;
    res_split.chunk_end       = split_end;
    res_split.final_chunk     = 1'b0;
    res_split.length_overflow = overflowed_q;

    res_final.chunk_start     = ws_next;
    res_final.chunk_end       = pos_next;
    res_final.final_chunk     = 1'b1;
    res_final.length_overflow = ovf_next;

    res0  = fire ? res_split : res_final;
    res1  = res_final;
    n_res = {1'b0, fire} + {1'b0, in_data_i.last};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q        <= '0;
      window_start_q    <= '0;
      split_candidate_q <= '0;
      candidate_valid_q <= 1'b0;
      prev_term_q       <= 1'b0;
      overflowed_q      <= 1'b0;
    end else if (accept) begin
      if (in_data_i.last) begin
        // end of text: back to idle
        position_q        <= '0;
        window_start_q    <= '0;
        split_candidate_q <= '0;
        candidate_valid_q <= 1'b0;
        prev_term_q       <= 1'b0;
        overflowed_q      <= 1'b0;
      end else begin
        position_q        <= pos_next;
        window_start_q    <= ws_next;
        split_candidate_q <= cand;
        candidate_valid_q <= cand_vld;
        prev_term_q       <= full ? prev_term_q
                                  : satc_pkg::is_terminator(in_data_i.code_unit);
        overflowed_q      <= ovf_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue: up to two beats pushed per accept, one popped per ready cycle
  // ---------------------------------------------------------------------------
  logic [1:0]      n_push;
  logic [QPTR-1:0] wr_ptr_p1;

  assign n_push    = accept ? n_res : 2'd0;
  assign wr_ptr_p1 = wr_ptr_q + QPTR'(1);

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      q_mem[wr_ptr_q] <= res0;
    end
    if (n_push == 2'd2) begin
      q_mem[wr_ptr_p1] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPTR'(n_push);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR'(1);
      end
      count_q <= count_q + QCNT'(n_push) - QCNT'(pop);
    end
  end

endmodule
